[hw/rtl/scsa_pkg.sv]
// package for the slab allocator: sizes, codes, state encoding, item types and helpers
// no dependencies
package scsa_pkg;

    localparam int PageBytes     = 4096;
    localparam int MaxPages      = 16;
    localparam int MaxSmallBytes = 512;
    localparam int HeaderBytes   = 24;
    localparam int DataBytes     = PageBytes - HeaderBytes;
    localparam int GranPerPage   = PageBytes / 8;
    localparam int NumBins       = 8;

    localparam int PageW = $clog2(MaxPages);
    localparam int OffW  = $clog2(PageBytes);
    localparam int GranW = $clog2(GranPerPage);
    localparam int LinkW = PageW + GranW;
    localparam int BinW  = $clog2(NumBins);

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_SMALL = 2'd1,
        ST_OOM       = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } t_state;

    // request item
    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] req_size;
        logic [31:0] req_align;
        logic [31:0] free_addr;
    } t_req;

    // result item
    typedef struct packed {
        t_status     status;
        logic [15:0] slot_addr;
    } t_rsp;

    // link memory request from control to memory
    typedef struct packed {
        logic             rd;
        logic             wr;
        logic [LinkW-1:0] addr;
        logic [OffW:0]    wdata;
    } t_link_req;

    // bin index of a size in 1..MaxSmallBytes
    function automatic logic [BinW-1:0] bin_of(input logic [31:0] size);
        logic [31:0] t;
        logic [BinW-1:0] b;
        t = (size - 32'd1) >> 2;
        b = '0;
        for (int i = 1; i < 32; i++) begin
            if (t[i]) b = BinW'(i);
        end
        return b;
    endfunction

endpackage

[hw/rtl/scsa_if.sv]
// valid/ready channels carrying one request item and one result item
// depends on scsa_pkg
interface scsa_req_if
    import scsa_pkg::*;
();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface scsa_rsp_if
    import scsa_pkg::*;
();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/scsa_link_mem.sv]
// slot link memory, one word per 8-byte granule, registered read
// depends on scsa_pkg
module scsa_link_mem
    import scsa_pkg::*;
(
    input  logic          i_clk,
    input  t_link_req     i_req,
    output logic [OffW:0] o_rdata
);
    logic [OffW:0] r_mem [MaxPages*GranPerPage];
    logic [OffW:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) r_mem[i_req.addr] <= i_req.wdata;
        if (i_req.rd) r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/size_class_slab_allocator.sv]
// Slab allocator over 16 pages of 4096 bytes, with seven size classes from 8 to 512 bytes.
// One item is in flight at a time. An allocation is decoded and its slot link read is issued
// in the cycle it is accepted, page headers are updated from the link word in the next cycle,
// and the result is offered from the cycle after that. Frees and rejected requests skip the
// read state. The next item is accepted once the result has been taken. No clearing pass
// after reset.
// depends on scsa_pkg, scsa_if, scsa_link_mem
module size_class_slab_allocator
    import scsa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    scsa_req_if.sink   i_req,
    scsa_rsp_if.source o_rsp
);
    t_state r_state, n_state;
    logic [OffW:0]  r_free_head [MaxPages];
    logic [OffW:0]  r_fresh     [MaxPages];
    logic [BinW-1:0] r_class    [MaxPages];
    logic [PageW:0] r_next      [MaxPages];
    logic [PageW:0] r_bin_head  [NumBins];
    logic [PageW:0] r_used;

    logic [PageW-1:0] r_page;
    logic [BinW-1:0]  r_bin;
    logic             r_fresh_pg;
    logic [1:0]       r_status;
    logic [15:0]      r_addr;

    t_req in_d;
    t_link_req lreq;
    logic [OffW:0] link_rd;

    assign in_d = i_req.data;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.data  = {r_status, r_addr};

    scsa_link_mem u_mem (.i_clk(i_clk), .i_req(lreq), .o_rdata(link_rd));

    // decode of the accepted item
    logic [BinW-1:0] a_bin;
    logic [OffW+1:0] a_item;
    logic a_bad, a_oom, a_empty;
    logic [PageW:0] a_pg;
    logic [PageW-1:0] f_pg;
    logic [OffW-1:0] f_off;
    logic [OffW+1:0] f_item;
    logic f_bad;
    logic [OffW:0] f_offr;

    always_comb begin
        a_bin   = bin_of(in_d.req_size);
        a_item  = (OffW+2)'(8) << a_bin;
        a_bad   = (in_d.req_size == 32'd0) || (in_d.req_size > 32'(MaxSmallBytes))
                  || (in_d.req_align > in_d.req_size) || (a_item > (OffW+2)'(DataBytes));
        a_pg    = r_bin_head[a_bin];
        a_empty = a_pg[PageW];
        a_oom   = a_empty && (r_used == (PageW+1)'(MaxPages));
        f_pg    = in_d.free_addr[OffW +: PageW];
        f_off   = in_d.free_addr[OffW-1:0];
        f_item  = (OffW+2)'(8) << r_class[f_pg];
        f_bad   = (in_d.free_addr >= 32'(MaxPages*PageBytes))
                  || ({1'b0, f_pg} >= r_used) || (f_off >= OffW'(DataBytes));
        f_offr  = (OffW+1)'({1'b0, f_off} & ~(f_item[OffW:0] - 1'b1));
    end

    logic [OffW:0]   p_o;
    logic [OffW+1:0] p_item, p_nxt;
    logic            p_reuse;
    always_comb begin
        p_item  = (OffW+2)'(8) << r_bin;
        p_o     = r_fresh_pg ? '0 : r_free_head[r_page];
        p_reuse = !r_fresh_pg && (p_o < r_fresh[r_page]);
        p_nxt   = p_reuse ? {1'b0, link_rd} : {1'b0, p_o} + p_item;
    end

    always_comb begin
        lreq = '0;
        if (r_state == S_IDLE && i_req.valid && in_d.cmd == CMD_ALLOC) begin
            lreq.rd   = 1'b1;
            lreq.addr = {a_pg[PageW-1:0], r_free_head[a_pg[PageW-1:0]][OffW-1:3]};
        end else if (r_state == S_IDLE && i_req.valid && !f_bad) begin
            lreq.wr    = 1'b1;
            lreq.addr  = {f_pg, f_offr[OffW-1:3]};
            lreq.wdata = r_free_head[f_pg];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_req.valid) n_state = (in_d.cmd == CMD_ALLOC && !a_bad && !a_oom)
                                                ? S_READ : S_OUT;
            S_READ:  n_state = S_OUT;
            S_OUT:   if (o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            for (int i = 0; i < MaxPages; i++) r_next[i] <= (PageW+1)'(MaxPages);
            for (int i = 0; i < NumBins; i++) r_bin_head[i] <= (PageW+1)'(MaxPages);
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_req.valid) begin
                r_addr <= '0;
                if (in_d.cmd == CMD_ALLOC) begin
                    r_bin <= a_bin;
                    r_status <= a_bad ? ST_NOT_SMALL : (a_oom ? ST_OOM : ST_OK);
                    r_fresh_pg <= a_empty;
                    r_page <= a_empty ? r_used[PageW-1:0] : a_pg[PageW-1:0];
                end else if (f_bad) begin
                    r_status <= ST_NOT_SMALL;
                end else begin
                    r_status <= ST_OK;
                    if ({1'b0, r_free_head[f_pg]} + f_item > (OffW+2)'(DataBytes)) begin
                        r_next[f_pg] <= r_bin_head[r_class[f_pg]];
                        r_bin_head[r_class[f_pg]] <= {1'b0, f_pg};
                    end
                    r_free_head[f_pg] <= f_offr;
                end
            end
            if (r_state == S_READ) begin
                r_addr <= 16'({r_page, p_o[OffW-1:0]});
                if (r_fresh_pg) begin
                    r_used <= r_used + 1'b1;
                    r_class[r_page] <= r_bin;
                end
                if (!p_reuse) r_fresh[r_page] <= p_nxt[OffW:0];
                r_free_head[r_page] <= p_nxt[OffW:0];
                if (p_nxt + p_item > (OffW+2)'(DataBytes)) begin
                    r_bin_head[r_bin] <= r_fresh_pg ? (PageW+1)'(MaxPages) : r_next[r_page];
                    r_next[r_page] <= (PageW+1)'(MaxPages);
                end else if (r_fresh_pg) begin
                    r_bin_head[r_bin] <= {1'b0, r_page};
                    r_next[r_page] <= (PageW+1)'(MaxPages);
                end
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= (PageW+1)'(MaxPages))
        else $error("page count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_OUT))
        else $error("read stage did not finish");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && r_status != ST_OK) |-> (r_addr == 16'd0))
        else $error("address on failed item");
endmodule

[sim/tb_size_class_slab_allocator.sv]
// testbench for size_class_slab_allocator: directed and random allocate/free items
// checked against an in-bench predictor of the page and bin lists
// depends on scsa_pkg, scsa_if and the allocator rtl
module tb_size_class_slab_allocator;
    import scsa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NoPage = MaxPages;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    scsa_req_if req_ch ();
    scsa_rsp_if rsp_ch ();

    size_class_slab_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #4 i_clk = ~i_clk;

    // predicted state
    int unsigned link_mem [MaxPages*GranPerPage];
    int unsigned free_head [MaxPages];
    int unsigned fresh_mark [MaxPages];
    int unsigned page_bin [MaxPages];
    int unsigned next_page [MaxPages];
    int unsigned bin_first [NumBins];
    int unsigned claimed_pages;

    t_rsp pending_rsp [$];
    int unsigned live_slots [$];
    int errors = 0;
    int n_ok = 0, n_rej = 0, n_oom = 0, n_free = 0, n_items = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    function automatic int unsigned size_bin(int unsigned size);
        int unsigned t;
        int unsigned b;
        t = (size - 1) >> 2;
        b = 0;
        while (t > 1) begin
            t = t >> 1;
            b++;
        end
        return b;
    endfunction

    task automatic predict_result(input t_req r, output t_rsp e);
        int unsigned bin, slot, p, o, nxt, off;
        e.status = ST_OK;
        e.slot_addr = '0;
        if (r.cmd == CMD_ALLOC) begin
            if (r.req_size == 0 || r.req_size > MaxSmallBytes || r.req_align > r.req_size) begin
                e.status = ST_NOT_SMALL;
                return;
            end
            bin = size_bin(r.req_size) & (NumBins - 1);
            slot = 8 << bin;
            if (slot > DataBytes) begin
                e.status = ST_NOT_SMALL;
                return;
            end
            p = bin_first[bin];
            if (p >= NoPage) begin
                if (claimed_pages >= MaxPages) begin
                    e.status = ST_OOM;
                    return;
                end
                p = claimed_pages;
                free_head[p] = 0;
                fresh_mark[p] = 0;
                page_bin[p] = bin;
                next_page[p] = NoPage;
                bin_first[bin] = p;
                claimed_pages++;
            end
            o = free_head[p];
            if (o < fresh_mark[p]) begin
                nxt = link_mem[p*GranPerPage + ((o % PageBytes) >> 3)];
            end else begin
                nxt = o + slot;
                fresh_mark[p] = nxt;
            end
            free_head[p] = nxt;
            if (nxt + slot > DataBytes) begin
                bin_first[bin] = next_page[p];
                next_page[p] = NoPage;
            end
            e.slot_addr = 16'(p*PageBytes + o);
        end else begin
            if (r.free_addr >= MaxPages*PageBytes) begin
                e.status = ST_NOT_SMALL;
                return;
            end
            p = r.free_addr / PageBytes;
            off = r.free_addr % PageBytes;
            if (p >= claimed_pages || off >= DataBytes) begin
                e.status = ST_NOT_SMALL;
                return;
            end
            bin = page_bin[p] & (NumBins - 1);
            slot = 8 << bin;
            off = off - (off % slot);
            if (free_head[p] + slot > DataBytes) begin
                next_page[p] = bin_first[bin];
                bin_first[bin] = p;
            end
            link_mem[p*GranPerPage + (off >> 3)] = free_head[p];
            free_head[p] = off;
        end
    endtask

    task automatic send_item(input t_req r);
        t_rsp e;
        int idx;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_result(r, e);
        pending_rsp.push_back(e);
        n_items++;
        if (r.cmd == CMD_FREE && e.status == ST_OK) begin
            n_free++;
            for (idx = 0; idx < live_slots.size(); idx++) begin
                if (live_slots[idx] == r.free_addr) begin
                    live_slots.delete(idx);
                    break;
                end
            end
        end else if (e.status == ST_OK) begin
            n_ok++;
            live_slots.push_back(e.slot_addr);
        end else if (e.status == ST_OOM) begin
            n_oom++;
        end else begin
            n_rej++;
        end
    endtask

    task automatic send_alloc(input int unsigned size, input int unsigned align);
        t_req r;
        r.cmd = CMD_ALLOC;
        r.req_size = size;
        r.req_align = align;
        r.free_addr = $urandom;
        send_item(r);
    endtask

    task automatic send_free(input int unsigned addr);
        t_req r;
        r.cmd = CMD_FREE;
        r.req_size = $urandom;
        r.req_align = $urandom;
        r.free_addr = addr;
        send_item(r);
    endtask

    // response checking and receiver stalls
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t unexpected result status=%0d addr=%h", $time,
                         rsp_ch.data.status, rsp_ch.data.slot_addr);
                errors++;
            end else begin
                e = pending_rsp.pop_front();
                if (rsp_ch.data.status !== e.status) begin
                    $display("%0t status mismatch expected=%0d actual=%0d", $time,
                             e.status, rsp_ch.data.status);
                    errors++;
                end
                if (rsp_ch.data.slot_addr !== e.slot_addr) begin
                    $display("%0t slot_addr mismatch expected=%h actual=%h", $time,
                             e.slot_addr, rsp_ch.data.slot_addr);
                    errors++;
                end
            end
        end
        rsp_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    task automatic test_edge_sizes();
        send_alloc(0, 0);
        send_alloc(513, 0);
        send_alloc(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_alloc(16, 17);
        send_alloc(1, 1);
        send_alloc(8, 0);
        send_alloc(9, 9);
        send_alloc(512, 512);
    endtask

    task automatic test_free_cases();
        send_free(3);
        send_free(DataBytes);
        send_free(5*PageBytes);
        send_free(MaxPages*PageBytes);
        send_free(32'hFFFF_FFFF);
        send_free(200);
        send_alloc(4, 0);
        send_alloc(4, 0);
    endtask

    task automatic test_full_page();
        int i;
        for (i = 0; i < 8; i++) send_alloc(400, 8);
        send_free(PageBytes + 512);
        send_alloc(300, 0);
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        int i;
        int unsigned size, k;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (i = 0; i < count; i++) begin
            k = $urandom_range(99);
            if (k < 45) begin
                size = ($urandom_range(3) == 0) ? $urandom_range(1, 512)
                                                : $urandom_range(1, 64);
                send_alloc(size, $urandom_range(size));
            end else if (k < 80 && live_slots.size() > 0) begin
                send_free(live_slots[$urandom_range(live_slots.size() - 1)]
                          + ($urandom_range(3) == 0 ? $urandom_range(7) : 0));
            end else if (k < 88) begin
                send_free($urandom_range(MaxPages*PageBytes - 1));
            end else if (k < 94) begin
                send_free($urandom);
            end else begin
                send_alloc($urandom, $urandom);
            end
        end
    endtask

    initial begin
        int waited;
        foreach (link_mem[i]) link_mem[i] = 0;
        foreach (next_page[i]) begin
            next_page[i] = NoPage;
            free_head[i] = 0;
            fresh_mark[i] = 0;
            page_bin[i] = 0;
        end
        foreach (bin_first[i]) bin_first[i] = NoPage;
        claimed_pages = 0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_sizes();
        test_free_cases();
        test_full_page();
        test_random(330, 0, 0);
        test_random(330, 86, 0);
        test_random(330, 0, 86);
        test_random(330, 8, 8);
        req_ch.valid <= 1'b0;
        waited = 0;
        while (pending_rsp.size() > 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        $display("ran %0d items: %0d allocations, %0d frees, %0d rejected, %0d out of memory",
                 n_items, n_ok, n_free, n_rej, n_oom);
        $display("pages claimed %0d, results still pending %0d", claimed_pages,
                 pending_rsp.size());
        if (errors == 0 && pending_rsp.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end

endmodule
